// ===== src/sor_pkg.sv =====
// Package: shared constants, codes and saturating arithmetic helpers of the SOR solver.
package sor_pkg;

  // Default number of unknowns that the stores are sized for.
  localparam int MaxDimDef = 8;

  // Field widths.
  localparam int OpW    = 2;
  localparam int IdxFw  = 3;
  localparam int ValW   = 32;
  localparam int OmegaW = 18;
  localparam int IterW  = 16;
  localparam int NUsedW = 4;
  localparam int TolW   = 32;
  localparam int AccW   = 64;
  localparam int PaddrW = 4;

  // Largest step magnitude, 2^40.
  localparam logic [40:0] StepCap = 41'h100_0000_0000;

  // Register reset values.
  localparam logic [NUsedW-1:0] NUsedRst = 4'd3;
  localparam logic [IterW-1:0]  MaxIterRst = 16'd1000;
  localparam logic [TolW-1:0]   TolRst = 32'd28147;

  // Operation codes of a request.
  typedef enum logic [OpW-1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_SOLVE    = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  // Register byte addresses.
  localparam logic [PaddrW-1:0] AddrNUsed = 4'h0;
  localparam logic [PaddrW-1:0] AddrMaxIt = 4'h4;
  localparam logic [PaddrW-1:0] AddrTol   = 4'h8;

  // Divider handshake status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Signed 64-bit add that saturates.
  function automatic logic signed [63:0] sat_add_s64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Signed 64-bit subtract that saturates.
  function automatic logic signed [63:0] sat_sub_s64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Saturate a 43-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat_s32(logic signed [42:0] v);
    if (v > 43'sh000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -43'sh000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== src/sor_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sor_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/sor_div.sv =====
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module sor_div
  import sor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [63:0] quotient_o,
  output div_status_t status_o
);

  logic [63:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_sh;

  // One quotient bit per step.
  always_comb begin
    rem_sh = {rem_q[31:0], dvd_q[63]};
    dvd_d  = {dvd_q[62:0], 1'b0};
    rem_d  = rem_sh;
    if (rem_sh >= {1'b0, dsr_q}) begin
      rem_d    = rem_sh - {1'b0, dsr_q};
      dvd_d[0] = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd63;
      end else if (busy_q) begin
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o    = dvd_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== src/sor_linear_solver_top.sv =====
// Top level: SOR linear solver with configuration port, stores and sweep sequencer.
// A load request is written into the store as it is taken; a solve is paced by
// the one-bit-per-cycle divider and the single coefficient memory read port.
// Results then leave one at a time while the master side is ready.
// Requests are taken only while no solve runs; the n results follow in index order.
// Reset clears control state and the registers; stores are not cleared, the solution
// valid bits are cleared at each solve.
module sor_linear_solver_top
  import sor_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Request stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: row[2:0], col[5:3], entry_value[37:6], omega[55:38]
  input  logic [55:0]       s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]        s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: index[2:0], solution[34:3], iterations[50:35], zero fill[55:51]
  output logic [55:0]       m_axis_tdata,
  // tuser: diag_fault[0]
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int IdxW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CntW   = $clog2(MAX_DIM + 1);
  localparam int ADepth = MAX_DIM * MAX_DIM + MAX_DIM;
  localparam int AAw    = $clog2(ADepth);
  localparam int NLimit = (MAX_DIM < 8) ? MAX_DIM : 8;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ROW, S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_RHS_RD, S_RHS_WAIT,
    S_DIV_START, S_DIV_WAIT, S_MUL_LO, S_MUL_HI, S_STEP, S_SQ, S_NORM, S_ROW_NEXT,
    S_EMIT_RD, S_EMIT_LD
  } state_e;

  state_e state_q;

  // Registers.
  logic [NUsedW-1:0] n_used_q;
  logic [IterW-1:0]  max_it_q;
  logic [TolW-1:0]   tol_q;

  // Sequencer state.
  logic [CntW-1:0]   n_q;
  logic [IdxW-1:0]   i_q, j_q, k_q;
  logic [OmegaW-1:0] w_q;
  logic [IterW-1:0]  sweep_q;
  logic [AccW-1:0]   norm_q;
  logic              go_q, fault_q;
  logic [MAX_DIM-1:0] vld_q;
  logic              vld_rd_q;

  // Datapath registers.
  logic signed [63:0] prod_q, acc_q, r_q;
  logic signed [31:0] d_q, old_q;
  logic [63:0]        mq_q;
  logic               neg_q;
  logic [45:0]        plo_q, phi_q;
  logic [31:0]        absdiff_q;
  logic [63:0]        sq_q;

  // Output register.
  logic              m_valid_q;
  logic [IdxFw-1:0]  o_index_q;
  logic [31:0]       o_sol_q;
  logic [IterW-1:0]  o_iter_q;
  logic              o_fault_q, o_last_q;

  // Request fields.
  logic [2:0]        in_row, in_col;
  logic [31:0]       in_val;
  logic [OmegaW-1:0] in_omega;
  logic              s_fire, cfg_wr;

  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[5:3];
  assign in_val   = s_axis_tdata[37:6];
  assign in_omega = s_axis_tdata[55:38];
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr)
      AddrNUsed: prdata = {28'd0, n_used_q};
      AddrMaxIt: prdata = {16'd0, max_it_q};
      AddrTol:   prdata = tol_q;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_used_q <= NUsedRst;
      max_it_q <= MaxIterRst;
      tol_q    <= TolRst;
    end else if (cfg_wr) begin
      case (paddr)
        AddrNUsed: n_used_q <= pwdata[NUsedW-1:0];
        AddrMaxIt: max_it_q <= pwdata[IterW-1:0];
        AddrTol:   tol_q    <= pwdata;
        default:   ;
      endcase
    end
  end

  // Coefficient and right-hand-side memory.
  logic           a_we;
  logic [AAw-1:0] a_waddr, a_raddr;
  logic [31:0]    a_rdata;

  always_comb begin
    a_we    = 1'b0;
    a_waddr = '0;
    if (s_fire && (s_axis_tuser == OP_LOAD_A) && (int'(in_row) < MAX_DIM) &&
        (int'(in_col) < MAX_DIM)) begin
      a_we    = 1'b1;
      a_waddr = AAw'(in_row) * AAw'(MAX_DIM) + AAw'(in_col);
    end else if (s_fire && (s_axis_tuser == OP_LOAD_B) && (int'(in_row) < MAX_DIM)) begin
      a_we    = 1'b1;
      a_waddr = AAw'(MAX_DIM * MAX_DIM) + AAw'(in_row);
    end
  end

  always_comb begin
    if (state_q == S_RHS_RD) begin
      a_raddr = AAw'(MAX_DIM * MAX_DIM) + AAw'(i_q);
    end else begin
      a_raddr = AAw'(i_q) * AAw'(MAX_DIM) + AAw'(j_q);
    end
  end

  sor_ram #(.Width(ValW), .Depth(ADepth)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (in_val),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // Solution memory; an entry not written in this solve reads as zero.
  logic            x_we;
  logic [IdxW-1:0] x_raddr;
  logic [31:0]     x_rdata, x_rd;
  logic signed [31:0] new_x;

  assign x_we    = (state_q == S_STEP);
  assign x_raddr = (state_q == S_EMIT_RD || state_q == S_EMIT_LD) ? k_q : j_q;
  assign x_rd    = vld_rd_q ? x_rdata : '0;

  sor_ram #(.Width(ValW), .Depth(MAX_DIM)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (i_q),
    .wdata_i (new_x),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  // Divider on magnitudes.
  logic [63:0]  div_dvd, div_q;
  logic [31:0]  div_dsr;
  div_status_t  div_st;

  assign div_dvd = r_q[63] ? (64'd0 - r_q) : r_q;
  assign div_dsr = d_q[31] ? (32'd0 - d_q) : d_q;

  sor_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIV_START),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (div_q),
    .status_o   (div_st)
  );

  // Step, relaxed update and difference.
  logic [74:0]        step_prod;
  logic [40:0]        mag;
  logic signed [41:0] step;
  logic signed [32:0] diff;
  logic               big;

  always_comb begin
    big       = |mq_q[63:56];
    step_prod = {1'b0, phi_q, 28'd0} + {29'd0, plo_q};
    if (w_q == '0) begin
      mag = '0;
    end else if (big || (step_prod[74:16] > {18'd0, StepCap})) begin
      mag = StepCap;
    end else begin
      mag = step_prod[56:16];
    end
    step  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    new_x = sat_s32({{11{old_q[31]}}, old_q} + {step[41], step});
    diff  = {new_x[31], new_x} - {old_q[31], old_q};
  end

  // Clamped number of unknowns.
  logic [CntW-1:0] n_sel;
  always_comb begin
    if (n_used_q == '0) begin
      n_sel = CntW'(1);
    end else if (int'(n_used_q) > NLimit) begin
      n_sel = CntW'(NLimit);
    end else begin
      n_sel = CntW'(n_used_q);
    end
  end

  logic [64:0] norm_sum;
  logic        j_last, i_last, k_last;
  assign norm_sum = {1'b0, norm_q} + {1'b0, sq_q};
  assign j_last   = (CntW'(j_q) == n_q - CntW'(1));
  assign i_last   = (CntW'(i_q) == n_q - CntW'(1));
  assign k_last   = (CntW'(k_q) == n_q - CntW'(1));

  // Control state machine and sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      vld_q     <= '0;
      vld_rd_q  <= 1'b0;
      sweep_q   <= '0;
      norm_q    <= '0;
      go_q      <= 1'b0;
      fault_q   <= 1'b0;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      vld_rd_q <= vld_q[x_raddr];
      // The emit state drives the output valid itself.
      if (m_valid_q && m_axis_tready && (state_q != S_EMIT_LD)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire && (s_axis_tuser == OP_SOLVE)) begin
            n_q     <= n_sel;
            vld_q   <= '0;
            sweep_q <= '0;
            norm_q  <= '0;
            go_q    <= 1'b1;
            fault_q <= 1'b0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (go_q && (({1'b0, sweep_q} + 17'd1) < {1'b0, max_it_q})) begin
            i_q     <= '0;
            norm_q  <= '0;
            state_q <= S_ROW;
          end else begin
            k_q     <= '0;
            state_q <= S_EMIT_RD;
          end
        end
        S_ROW: begin
          j_q     <= '0;
          state_q <= S_MAC_RD;
        end
        S_MAC_RD:  state_q <= S_MAC_MUL;
        S_MAC_MUL: state_q <= S_MAC_ACC;
        S_MAC_ACC: begin
          if (j_last) begin
            state_q <= S_RHS_RD;
          end else begin
            j_q     <= j_q + IdxW'(1);
            state_q <= S_MAC_RD;
          end
        end
        S_RHS_RD: state_q <= S_RHS_WAIT;
        S_RHS_WAIT: begin
          if (d_q == '0) begin
            fault_q <= 1'b1;
            state_q <= S_ROW_NEXT;
          end else begin
            state_q <= S_DIV_START;
          end
        end
        S_DIV_START: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_st.done) begin
            state_q <= S_MUL_LO;
          end
        end
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_STEP;
        S_STEP: begin
          vld_q[i_q] <= 1'b1;
          state_q    <= S_SQ;
        end
        S_SQ: state_q <= S_NORM;
        S_NORM: begin
          norm_q  <= norm_sum[64] ? {AccW{1'b1}} : norm_sum[63:0];
          state_q <= S_ROW_NEXT;
        end
        S_ROW_NEXT: begin
          if (i_last) begin
            sweep_q <= sweep_q + IterW'(1);
            go_q    <= (norm_q >= {32'd0, tol_q});
            state_q <= S_CHECK;
          end else begin
            i_q     <= i_q + IdxW'(1);
            state_q <= S_ROW;
          end
        end
        S_EMIT_RD: state_q <= S_EMIT_LD;
        S_EMIT_LD: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            if (k_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + IdxW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_fire && (s_axis_tuser == OP_SOLVE)) begin
          w_q <= in_omega;
        end
      end
      S_ROW: acc_q <= '0;
      S_MAC_MUL: begin
        prod_q <= $signed(a_rdata) * $signed(x_rd);
        if (j_q == i_q) begin
          d_q   <= a_rdata;
          old_q <= x_rd;
        end
      end
      S_MAC_ACC: acc_q <= sat_add_s64(acc_q, prod_q);
      S_RHS_WAIT: begin
        r_q <= sat_sub_s64({{8{a_rdata[31]}}, a_rdata, 24'd0}, acc_q);
      end
      S_DIV_WAIT: begin
        mq_q  <= div_q;
        neg_q <= r_q[63] ^ d_q[31];
      end
      S_MUL_LO: plo_q <= mq_q[27:0] * w_q;
      S_MUL_HI: phi_q <= mq_q[55:28] * w_q;
      S_STEP:   absdiff_q <= diff[32] ? 32'(-diff) : diff[31:0];
      S_SQ:     sq_q <= absdiff_q * absdiff_q;
      S_EMIT_LD: begin
        if (!m_valid_q || m_axis_tready) begin
          o_index_q <= IdxFw'(k_q);
          o_sol_q   <= x_rd;
          o_iter_q  <= sweep_q;
          o_fault_q <= fault_q;
          o_last_q  <= k_last;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, o_iter_q, o_sol_q, o_index_q};
  assign m_axis_tuser  = o_fault_q;
  assign m_axis_tlast  = o_last_q;

  // A solve request closes the request side on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tuser == OP_SOLVE)) |=> !s_axis_tready)
    else $error("request side still open after a solve request");

  // The flagged result carries the last index of the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (CntW'(o_index_q) == n_q - CntW'(1)))
    else $error("last flag on a result that is not the final index");

  // The divider is started only while it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_START) |-> !div_st.busy)
    else $error("divider started while busy");

endmodule

// ===== tb/tb.sv =====
// Testbench of the SOR linear solver: random systems, register settings and stream stalls.
`timescale 1ns / 1ps

module tb;
  import sor_pkg::*;

  localparam int  Dim       = 8;
  localparam int  LongStall = 600;
  localparam longint Limit  = 4000000;
  localparam logic [63:0] StepMax = 64'h100_0000_0000;

  // One request as offered on the slave side.
  typedef struct packed {
    op_e         op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] entry;
    logic [17:0] omega;
  } request_t;

  // One solution element as it should leave the block.
  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] solution;
    logic [15:0] iterations;
    logic        fault;
    logic        last;
  } element_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [55:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  sor_linear_solver_top uut (.*);

  // Shadow of the registers and stores.
  logic signed [31:0] coef_sh [Dim*Dim];
  logic signed [31:0] rhs_sh [Dim];
  logic signed [31:0] x_sh [Dim];
  logic [3:0]  n_sh;
  logic [15:0] maxit_sh;
  logic [31:0] tol_sh;

  request_t pending_q[$];
  element_t solution_q[$];
  request_t offered;
  int       req_gap;
  int       rsp_gap;
  int       stall_left;
  int       hold_asked;
  int       hold_seen;
  bit       calm;
  int       errors;
  int       items;
  int       solves;
  int       elements;
  int       faults_seen;
  longint   cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("%0t timeout with %0d results pending", $time, solution_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? 64'sh8000_0000_0000_0000
                                                   : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  // Updates one unknown in place; returns 1 when its diagonal is zero.
  function automatic bit relax_row(int i, int n, logic [17:0] w);
    longint acc, d, r, q, step, nx;
    logic [63:0] mq, mag;
    logic [81:0] prod;
    acc = 0;
    for (int j = 0; j < n; j++) begin
      acc = add_sat(acc, longint'(coef_sh[i*Dim+j]) * longint'(x_sh[j]));
    end
    d = longint'(coef_sh[i*Dim+i]);
    if (d == 0) return 1'b1;
    r = longint'(rhs_sh[i]) * 16777216;
    if (acc == 64'sh8000_0000_0000_0000) begin
      r = (r >= 0) ? 64'sh7FFF_FFFF_FFFF_FFFF : r - acc - 1 + 1;
      if (r < 0) r = add_sat(r, 64'sh7FFF_FFFF_FFFF_FFFF) + 1;
    end else begin
      r = add_sat(r, -acc);
    end
    if (r == 64'sh8000_0000_0000_0000 && d == -1) q = 64'sh7FFF_FFFF_FFFF_FFFF;
    else q = r / d;
    mq = q[63] ? 64'(-q) : 64'(q);
    prod = 82'(mq) * 82'(w);
    mag = (prod >> 16) > 82'(StepMax) ? StepMax : 64'(prod >> 16);
    step = q[63] ? -longint'(mag) : longint'(mag);
    nx = longint'(x_sh[i]) + step;
    if (nx > 64'sh7FFF_FFFF) x_sh[i] = 32'sh7FFF_FFFF;
    else if (nx < -64'sh8000_0000) x_sh[i] = 32'sh8000_0000;
    else x_sh[i] = nx[31:0];
    return 1'b0;
  endfunction

  // Applies one accepted request to the shadow and queues the solution it yields.
  function automatic void apply_request(request_t rq);
    int n;
    bit go, fault;
    logic [15:0] sweeps;
    logic signed [31:0] prev [Dim];
    logic [64:0] norm;
    longint df;
    logic [63:0] m;
    element_t e;
    case (rq.op)
      OP_LOAD_A: coef_sh[rq.row*Dim+rq.col] = rq.entry;
      OP_LOAD_B: rhs_sh[rq.row] = rq.entry;
      OP_SOLVE: begin
        n = (n_sh == 0) ? 1 : (n_sh > Dim) ? Dim : n_sh;
        for (int i = 0; i < Dim; i++) x_sh[i] = '0;
        sweeps = '0;
        go = 1'b1;
        fault = 1'b0;
        while (go && (32'(sweeps) + 1 < 32'(maxit_sh))) begin
          for (int i = 0; i < n; i++) begin
            prev[i] = x_sh[i];
            if (relax_row(i, n, rq.omega)) fault = 1'b1;
          end
          norm = '0;
          for (int i = 0; i < n; i++) begin
            df = longint'(x_sh[i]) - longint'(prev[i]);
            m = df < 0 ? 64'(-df) : 64'(df);
            norm = norm + 65'(m * m);
            if (norm[64]) norm = {1'b0, {64{1'b1}}};
          end
          sweeps++;
          go = norm[63:0] >= 64'(tol_sh);
        end
        for (int i = 0; i < n; i++) begin
          e.index = 3'(i);
          e.solution = x_sh[i];
          e.iterations = sweeps;
          e.fault = fault;
          e.last = (i == n - 1);
          solution_q.push_back(e);
        end
        solves++;
      end
      default: ;
    endcase
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      req_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(offered);
        items++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && pending_q.size() > 0 && $urandom_range(0, 11) == 0) begin
          req_gap <= $urandom_range(0, 13);
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          offered = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.omega, offered.entry, offered.col, offered.row};
          s_axis_tuser  <= offered.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rsp_gap       <= 0;
      stall_left    <= 0;
      hold_seen     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (solution_q.size() == 0) begin
          $display("%0t unexpected result: actual %h last %b", $time, m_axis_tdata,
                   m_axis_tlast);
          errors++;
        end else begin
          element_t e;
          e = solution_q.pop_front();
          if (m_axis_tdata[2:0] !== e.index) begin
            $display("%0t index: expected %0d actual %0d", $time, e.index, m_axis_tdata[2:0]);
            errors++;
          end
          if (m_axis_tdata[34:3] !== e.solution) begin
            $display("%0t solution: expected %h actual %h", $time, e.solution,
                     m_axis_tdata[34:3]);
            errors++;
          end
          if (m_axis_tdata[50:35] !== e.iterations) begin
            $display("%0t iterations: expected %0d actual %0d", $time, e.iterations,
                     m_axis_tdata[50:35]);
            errors++;
          end
          if (m_axis_tuser !== e.fault) begin
            $display("%0t diag_fault: expected %b actual %b", $time, e.fault, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $display("%0t last: expected %b actual %b", $time, e.last, m_axis_tlast);
            errors++;
          end
          elements++;
          if (e.fault) faults_seen++;
        end
      end
      // The long hold starts once the first result of the held solve shows up.
      if (hold_asked != hold_seen && m_axis_tvalid) begin
        hold_seen <= hold_asked;
        stall_left <= LongStall;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_gap <= $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(op_e op, int row, int col, logic [31:0] v, logic [17:0] w);
    request_t rq;
    rq.op = op;
    rq.row = 3'(row);
    rq.col = 3'(col);
    rq.entry = v;
    rq.omega = w;
    pending_q.push_back(rq);
  endtask

  // Loads a diagonally dominant system of size n; a partial load touches a few entries only.
  task automatic push_system(int n, bit partial);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (partial && $urandom_range(0, 3) != 0) continue;
        if (i == j) v = 32'($urandom_range(n + 1, 2 * n + 6)) << 24;
        else v = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        if (i == j && $urandom_range(0, 1)) v = -v;
        push_req(OP_LOAD_A, i, j, v, 18'($urandom));
      end
      if (!partial || $urandom_range(0, 1))
        push_req(OP_LOAD_B, i, $urandom_range(0, 7),
                 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000, 18'($urandom));
    end
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: push_req(OP_RESERVED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                  18'($urandom));
      1: push_req(OP_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                  18'($urandom));
      default: push_req(OP_LOAD_B, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                        18'($urandom));
    endcase
  endtask

  // Waits until every request is taken, every element seen and the block settled.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() > 0 || s_axis_tvalid || solution_q.size() > 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [PaddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      AddrNUsed: n_sh = data[3:0];
      AddrMaxIt: maxit_sh = data[15:0];
      default:   tol_sh = data;
    endcase
  endtask

  task automatic set_regs(int n, int maxit, logic [31:0] tol);
    drain();
    reg_write(AddrNUsed, 32'(n));
    reg_write(AddrMaxIt, 32'(maxit));
    reg_write(AddrTol, tol);
  endtask

  // Stimulus.
  initial begin
    int n, maxit, nsolves;
    logic [31:0] tol;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    errors = 0;
    items = 0;
    solves = 0;
    elements = 0;
    faults_seen = 0;
    cycles = 0;
    calm = 1'b0;
    hold_asked = 0;
    n_sh = NUsedRst;
    maxit_sh = MaxIterRst;
    tol_sh = TolRst;
    for (int i = 0; i < Dim; i++) x_sh[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, identity-like system, omega extremes, field extremes.
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) push_req(OP_LOAD_A, i, j, (i == j) ? 32'h0100_0000 : 0, 0);
      push_req(OP_LOAD_B, i, 7, 32'h0080_0000 * (i + 1), 18'h3FFFF);
    end
    push_req(OP_SOLVE, 0, 0, 0, 18'd65536);
    push_req(OP_SOLVE, 7, 7, 32'hFFFF_FFFF, 18'd0);
    push_req(OP_SOLVE, 0, 0, 0, 18'd131072);
    push_req(OP_LOAD_A, 7, 7, 32'h8000_0000, 0);
    push_req(OP_LOAD_B, 7, 0, 32'h7FFF_FFFF, 0);
    push_req(OP_RESERVED, 7, 7, 32'hFFFF_FFFF, 18'h3FFFF);
    // Zero diagonal in the middle row, then restored.
    push_req(OP_LOAD_A, 1, 1, 0, 0);
    push_req(OP_SOLVE, 0, 0, 0, 18'd65536);
    push_req(OP_LOAD_A, 1, 1, 32'h0100_0000, 0);
    drain();

    // Register extremes; the full 8x8 system loaded first stays in place for later steps.
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: set_regs(0, 0, 0);
        1: set_regs(15, 1, 32'hFFFF_FFFF);
        2: set_regs(8, 65535, 32'hFFFF_FFFF);
        3: set_regs(8, 400, 32'd1);
        4: set_regs(1, 12, 0);
        5: set_regs(8, 6, 0);
        default: set_regs(2, 65535, TolRst);
      endcase
      n = (k == 1 || k == 2 || k == 3 || k == 5) ? 8 : (k == 6) ? 2 : 1;
      if (k != 2 && k != 3 && k != 5) push_system(n, 1'b0);
      push_req(OP_SOLVE, 0, 0, 0, 18'($urandom_range(32768, 65536)));
      if (k == 5) begin
        // Receiver holds off while a second solve is offered behind the first.
        hold_asked++;
        push_req(OP_SOLVE, 0, 0, 0, 18'd65536);
        push_system(8, 1'b1);
      end
    end

    // Random phases.
    while (items < 350) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      maxit = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = $urandom_range(0, 100000);
        2: tol = $urandom;
        default: tol = 32'hFFFF_FFFF;
      endcase
      if (items > 300) calm = 1'b1;
      set_regs(n, maxit, tol);
      nsolves = $urandom_range(1, 3);
      for (int s = 0; s < nsolves; s++) begin
        push_system(n, s != 0);
        if ($urandom_range(0, 3) == 0) push_noise();
        if ($urandom_range(0, 7) == 0) push_req(OP_LOAD_A, 0, 0, 0, 0);
        push_req(OP_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                 18'($urandom_range(0, 131072)));
      end
      drain();
    end

    drain();
    repeat (50) @(negedge clk_i);
    $display("%0d requests, %0d solves, %0d elements checked (%0d with a zero diagonal)",
             items, solves, elements, faults_seen);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
